// ===== src/ppm_header_parser_macros.svh =====
// Assertion helpers shared by the parser RTL.
`ifndef PPM_HEADER_PARSER_MACROS_SVH
`define PPM_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PPM_HDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PPM_HDR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PPM_HDR_ASSERT(lbl, clk, rst_n, prop, msg)

`define PPM_HDR_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/ppm_hdr_pkg.sv =====
package ppm_hdr_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int VAL_W   = 16;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 11;
  localparam int PROD_W  = VAL_W + 4;

  // Longest line, newline excluded, is LINE_LIMIT - 1 bytes
  localparam int LINE_LIMIT = 1024;

  // Token queue between front and back end
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;
  localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT   = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EARLY = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  // Header line being parsed
  typedef enum logic [2:0] {
    LINE_TYPE = 3'b001,
    LINE_SIZE = 3'b010,
    LINE_MAXV = 3'b100
  } line_t;

  // Classified input byte
  typedef struct packed {
    logic [3:0] digit;
    logic       is_digit;
    logic       is_sp;
    logic       is_blank;
    logic       is_nl;
    logic       is_hash;
    logic       first;
    logic       last;
  } token_t;

endpackage

// ===== src/ppm_hdr_queue.sv =====
`include "ppm_header_parser_macros.svh"

module ppm_hdr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ppm_hdr_pkg::token_t push_tok,
  output logic              full,
  input  logic              pop,
  output ppm_hdr_pkg::token_t head_tok,
  output logic              empty
);
  import ppm_hdr_pkg::*;

  token_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  assign full     = (count_r == QUEUE_FULL);
  assign empty    = (count_r == '0);
  assign head_tok = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Token storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  `PPM_HDR_NEVER(a_no_overflow, clk, rst_n, push && full, "token pushed into full queue")
  `PPM_HDR_NEVER(a_no_underflow, clk, rst_n, pop && empty, "token popped from empty queue")
  `PPM_HDR_ASSERT(a_count_bound, clk, rst_n, count_r <= QUEUE_FULL, "queue count out of range")

endmodule

// ===== src/ppm_hdr_front.sv =====
module ppm_hdr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ppm_hdr_pkg::BYTE_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            pop,
  output ppm_hdr_pkg::token_t             head_tok,
  output logic                            empty
);
  import ppm_hdr_pkg::*;

  token_t tok;
  logic   full;
  logic   push;

  // Byte classification
  always_comb begin
    tok          = '0;
    tok.is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    tok.digit    = in_tdata[3:0];
    tok.is_sp    = (in_tdata == CH_SP);
    tok.is_blank = (in_tdata == CH_TAB) || (in_tdata == CH_VT) ||
                   (in_tdata == CH_FF)  || (in_tdata == CH_CR);
    tok.is_nl    = (in_tdata == CH_NL);
    tok.is_hash  = (in_tdata == CH_HASH);
    tok.first    = in_tuser;
    tok.last     = in_tlast;
  end

  assign in_tready = !full;
  assign push      = in_tvalid && !full;

  ppm_hdr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (tok),
    .full     (full),
    .pop      (pop),
    .head_tok (head_tok),
    .empty    (empty)
  );

endmodule

// ===== src/ppm_hdr_back.sv =====
`include "ppm_header_parser_macros.svh"

module ppm_hdr_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppm_hdr_pkg::token_t              head_tok,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [4*ppm_hdr_pkg::VAL_W-1:0]  out_tdata,
  output logic [ppm_hdr_pkg::STAT_W-1:0]   out_tuser
);
  import ppm_hdr_pkg::*;

  // Parse state
  line_t              line_r, line_nxt;
  logic               at_start_r, at_start_nxt;
  logic               in_cmt_r, in_cmt_nxt;
  logic               phase_r, phase_nxt;
  logic               begun_r, begun_nxt;
  logic               ended_r, ended_nxt;
  logic [VAL_W-1:0]   w_r, w_nxt;
  logic [VAL_W-1:0]   h_r, h_nxt;
  logic [VAL_W-1:0]   m_r, m_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [VAL_W-1:0]   cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;

  // Output register
  logic                 ovalid_r, ovalid_nxt;
  logic [4*VAL_W-1:0]   odata_r;
  status_t              ostat_r;

  // State after an optional new-file clear
  line_t              line_e;
  logic               at_start_e, in_cmt_e, phase_e, begun_e, ended_e, fin_e;
  logic [VAL_W-1:0]   w_e, h_e, m_e, cnt_e;
  logic [LEN_W-1:0]   len_e;

  logic               res_load;
  status_t            res_stat;
  logic [VAL_W-1:0]   acc_sel;
  logic [PROD_W-1:0]  prod;
  logic [VAL_W-1:0]   acc_new;
  logic               cmt;
  logic               feed;
  logic               too_long;

  assign pop = !empty && (!ovalid_r || out_tready);

  always_comb begin
    if (head_tok.first) begin
      line_e = LINE_TYPE; at_start_e = 1'b1; in_cmt_e = 1'b0; phase_e = 1'b0;
      begun_e = 1'b0; ended_e = 1'b0; w_e = '0; h_e = '0; m_e = '0;
      len_e = '0; cnt_e = '0; fin_e = 1'b0;
    end else begin
      line_e = line_r; at_start_e = at_start_r; in_cmt_e = in_cmt_r; phase_e = phase_r;
      begun_e = begun_r; ended_e = ended_r; w_e = w_r; h_e = h_r; m_e = m_r;
      len_e = len_r; cnt_e = cnt_r; fin_e = fin_r;
    end
  end

  // Shared multiply-by-ten accumulate, saturating
  always_comb begin
    acc_sel = (line_e == LINE_MAXV) ? m_e : (phase_e ? h_e : w_e);
    prod    = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + PROD_W'(head_tok.digit);
    acc_new = (prod > PROD_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : prod[VAL_W-1:0];
  end

  assign too_long = ({1'b0, len_e} + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(LINE_LIMIT);

  // One header byte per pop
  always_comb begin
    line_nxt = line_e; at_start_nxt = at_start_e; in_cmt_nxt = in_cmt_e;
    phase_nxt = phase_e; begun_nxt = begun_e; ended_nxt = ended_e;
    w_nxt = w_e; h_nxt = h_e; m_nxt = m_e; len_nxt = len_e;
    cnt_nxt = cnt_e; fin_nxt = fin_e;
    res_load = 1'b0;
    res_stat = ST_OK;
    cmt      = in_cmt_e;
    feed     = 1'b0;
    if (!fin_e) begin
      cnt_nxt = (cnt_e == {VAL_W{1'b1}}) ? cnt_e : cnt_e + 1'b1;
      if (head_tok.is_nl) begin
        if (in_cmt_e) begin
          in_cmt_nxt = 1'b0;
        end else if (line_e == LINE_MAXV) begin
          res_load = 1'b1;
        end else begin
          unique case (line_e)
            LINE_TYPE: line_nxt = LINE_SIZE;
            LINE_SIZE: line_nxt = LINE_MAXV;
            default:   line_nxt = line_e;
          endcase
          phase_nxt = 1'b0;
          begun_nxt = 1'b0;
          ended_nxt = 1'b0;
        end
        at_start_nxt = 1'b1;
        len_nxt      = '0;
        if (!res_load && head_tok.last) begin
          res_load = 1'b1;
          res_stat = ST_EARLY;
        end
      end else if (too_long) begin
        res_load = 1'b1;
        res_stat = ST_LONG;
      end else begin
        len_nxt      = len_e + 1'b1;
        cmt          = in_cmt_e || (at_start_e && head_tok.is_hash);
        in_cmt_nxt   = cmt;
        at_start_nxt = 1'b0;
        if (!cmt) begin
          if (line_e == LINE_SIZE && !phase_e && head_tok.is_sp) begin
            // first space ends the width
            phase_nxt = 1'b1;
            begun_nxt = 1'b0;
            ended_nxt = 1'b0;
          end else if ((line_e == LINE_SIZE || line_e == LINE_MAXV) && !ended_e) begin
            if (head_tok.is_digit) begin
              feed      = 1'b1;
              begun_nxt = 1'b1;
            end else if (!begun_e && (head_tok.is_sp || head_tok.is_blank)) begin
              // leading blank skipped
            end else begin
              ended_nxt = 1'b1;
            end
          end
        end
        if (feed) begin
          if (line_e == LINE_MAXV) begin
            m_nxt = acc_new;
          end else if (phase_e) begin
            h_nxt = acc_new;
          end else begin
            w_nxt = acc_new;
          end
        end
        if (head_tok.last) begin
          res_load = 1'b1;
          res_stat = ST_EARLY;
        end
      end
      if (res_load) begin
        fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_TYPE; at_start_r <= 1'b1; in_cmt_r <= 1'b0; phase_r <= 1'b0;
      begun_r <= 1'b0; ended_r <= 1'b0; w_r <= '0; h_r <= '0; m_r <= '0;
      len_r <= '0; cnt_r <= '0; fin_r <= 1'b0;
    end else if (pop) begin
      line_r <= line_nxt; at_start_r <= at_start_nxt; in_cmt_r <= in_cmt_nxt;
      phase_r <= phase_nxt; begun_r <= begun_nxt; ended_r <= ended_nxt;
      w_r <= w_nxt; h_r <= h_nxt; m_r <= m_nxt; len_r <= len_nxt;
      cnt_r <= cnt_nxt; fin_r <= fin_nxt;
    end
  end

  // Result register: loads on a result, clears on transfer
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (pop && res_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_load) begin
      if (res_stat == ST_OK) begin
        odata_r <= {cnt_nxt, m_e, h_e, w_e};
      end else begin
        odata_r <= {cnt_nxt, {3*VAL_W{1'b0}}};
      end
      ostat_r <= res_stat;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;

  `PPM_HDR_NEVER(a_no_result_when_done, clk, rst_n,
                 pop && res_load && fin_r && !head_tok.first, "result after finished header")
  `PPM_HDR_ASSERT(a_ok_on_maxval, clk, rst_n,
                  (pop && res_load && res_stat == ST_OK) |-> (line_e == LINE_MAXV && head_tok.is_nl),
                  "ok result off the maxval newline")
  `PPM_HDR_NEVER(a_no_overwrite, clk, rst_n,
                 pop && res_load && ovalid_r && !out_tready, "pending result overwritten")

endmodule

// ===== src/ppm_header_parser.sv =====
// PPM header parser: takes a PPM file one byte per transfer (in_tuser marks
// the first byte of a file, in_tlast the last available byte), skips '#'
// comment lines, and after the newline that ends the maxval line gives one
// result with width, height, maxval and the header byte count; truncated
// data or a line of LINE_LIMIT bytes or more gives an error status instead,
// and later bytes are dropped until the next first byte. One byte is taken
// every clock cycle while in_tready is high; the byte that ends the header
// is held in the classify queue, then goes through the parse stage and its
// multiply-by-ten accumulate into the result register. out_tready low stalls
// the input only once the two-entry queue behind the result register fills.
module ppm_header_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ppm_hdr_pkg::BYTE_W-1:0]   in_tdata,   // data_byte
  input  logic                             in_tuser,   // first_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // image_width, image_height, max_value, header_bytes
  output logic [4*ppm_hdr_pkg::VAL_W-1:0]  out_tdata,
  output logic [ppm_hdr_pkg::STAT_W-1:0]   out_tuser   // status
);
  import ppm_hdr_pkg::*;

  token_t head_tok;
  logic   empty;
  logic   pop;

  ppm_hdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .head_tok  (head_tok),
    .empty     (empty)
  );

  ppm_hdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_tok   (head_tok),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sim/ppm_header_parser_tb.sv =====
`timescale 1ns / 100ps

module ppm_header_parser_tb;
  import ppm_hdr_pkg::*;

  // One byte of the stream, or a marker that holds the sender until all results are in
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              pause;
  } stim_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] width;
    logic [VAL_W-1:0] height;
    logic [VAL_W-1:0] maxval;
    logic [VAL_W-1:0] nbytes;
    status_t          status;
  } hdr_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [4*VAL_W-1:0]     out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  ppm_header_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stim_item_t        byte_stream_q[$];
  hdr_result_t       header_expect_q[$];
  logic [BYTE_W-1:0] file_bytes[$];
  int unsigned       stream_len = 0;
  int unsigned       bytes_taken = 0;
  int unsigned       results_seen = 0;
  int unsigned       mismatches = 0;
  int unsigned       tick = 0;
  int unsigned       hold_left = 0;
  logic              hold_done = 1'b0;

  // no random idling on either side inside this window
  wire steady = (tick >= 300) && (tick < 900);

  // Parser state as seen by the predictor
  logic [1:0]       ps_line;
  logic             ps_line_start;
  logic             ps_comment;
  logic             ps_phase;
  logic             ps_digits;
  logic             ps_ended;
  logic [VAL_W-1:0] ps_width;
  logic [VAL_W-1:0] ps_height;
  logic [VAL_W-1:0] ps_maxval;
  int unsigned      ps_len;
  logic [VAL_W-1:0] ps_count;
  logic             ps_done;

  function automatic void clear_parse();
    ps_line       = 2'd0;
    ps_line_start = 1'b1;
    ps_comment    = 1'b0;
    ps_phase      = 1'b0;
    ps_digits     = 1'b0;
    ps_ended      = 1'b0;
    ps_width      = '0;
    ps_height     = '0;
    ps_maxval     = '0;
    ps_len        = 0;
    ps_count      = '0;
    ps_done       = 1'b0;
  endfunction

  function automatic void close_header(input status_t st, output hdr_result_t r);
    r.width  = (st == ST_OK) ? ps_width : '0;
    r.height = (st == ST_OK) ? ps_height : '0;
    r.maxval = (st == ST_OK) ? ps_maxval : '0;
    r.nbytes = ps_count;
    r.status = st;
    ps_done  = 1'b1;
  endfunction

  // Decimal accumulate with saturation; blanks skipped before the first digit
  function automatic logic [VAL_W-1:0] next_value(input logic [VAL_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [19:0] grown;
    if (ps_ended)
      return acc;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      grown = {4'd0, acc} * 20'd10 + {12'd0, b - CH_ZERO};
      ps_digits = 1'b1;
      return (grown > 20'd65535) ? 16'hFFFF : grown[15:0];
    end
    if (!ps_digits && (b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR))
      return acc;
    ps_ended = 1'b1;
    return acc;
  endfunction

  // Advance the predicted parser by one byte; returns 1 when a header result is due
  function automatic logic parse_byte(input logic [BYTE_W-1:0] b, input logic first,
                                      input logic last, output hdr_result_t r);
    r = '0;
    if (first)
      clear_parse();
    if (ps_done)
      return 1'b0;
    if (ps_count != 16'hFFFF)
      ps_count = ps_count + 16'd1;

    if (b == CH_NL) begin
      if (ps_comment) begin
        ps_comment = 1'b0;
      end else if (ps_line == 2'd2) begin
        close_header(ST_OK, r);
        return 1'b1;
      end else begin
        ps_line   = ps_line + 2'd1;
        ps_phase  = 1'b0;
        ps_digits = 1'b0;
        ps_ended  = 1'b0;
      end
      ps_line_start = 1'b1;
      ps_len = 0;
      if (last) begin
        close_header(ST_EARLY, r);
        return 1'b1;
      end
      return 1'b0;
    end

    if (ps_len + 1 >= LINE_LIMIT) begin
      close_header(ST_LONG, r);
      return 1'b1;
    end
    ps_len = ps_len + 1;

    if (ps_line_start && b == CH_HASH)
      ps_comment = 1'b1;
    ps_line_start = 1'b0;

    if (!ps_comment) begin
      if (ps_line == 2'd1) begin
        if (!ps_phase && b == CH_SP) begin
          ps_phase  = 1'b1;
          ps_digits = 1'b0;
          ps_ended  = 1'b0;
        end else if (!ps_phase) begin
          ps_width = next_value(ps_width, b);
        end else begin
          ps_height = next_value(ps_height, b);
        end
      end else if (ps_line == 2'd2) begin
        ps_maxval = next_value(ps_maxval, b);
      end
    end

    if (last) begin
      close_header(ST_EARLY, r);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [BYTE_W-1:0] any_but_nl();
    logic [BYTE_W-1:0] b;
    do
      b = 8'($urandom_range(255));
    while (b == CH_NL);
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      file_bytes.push_back(s[i]);
  endtask

  task automatic add_run(input logic [BYTE_W-1:0] b, input int n);
    repeat (n) file_bytes.push_back(b);
  endtask

  // Random decimal field, sometimes with a leading blank or sign
  task automatic add_value(input logic in_size);
    logic [BYTE_W-1:0] blanks[5] = '{CH_TAB, CH_VT, CH_FF, CH_CR, CH_SP};
    int unsigned n;
    if ($urandom_range(5) == 0)
      file_bytes.push_back(blanks[$urandom_range(in_size ? 3 : 4)]);
    if ($urandom_range(15) == 0)
      file_bytes.push_back($urandom_range(1) ? 8'h2D : 8'h2B);
    n = ($urandom_range(7) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 1);
    repeat (n) file_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic add_comments();
    repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0) begin
      file_bytes.push_back(CH_HASH);
      repeat ($urandom_range(20)) file_bytes.push_back(any_but_nl());
      file_bytes.push_back(CH_NL);
    end
  endtask

  // Well-formed header with random content
  task automatic build_header();
    add_comments();
    if ($urandom_range(3) != 0) begin
      add_text("P");
      file_bytes.push_back(8'(CH_ZERO + $urandom_range(7, 1)));
    end else begin
      repeat ($urandom_range(8, 1)) file_bytes.push_back(any_but_nl());
    end
    file_bytes.push_back(CH_NL);
    add_comments();
    add_value(1'b1);
    if ($urandom_range(9) != 0) begin
      file_bytes.push_back(CH_SP);
      add_value(1'b0);
    end
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1)) file_bytes.push_back(any_but_nl());
    file_bytes.push_back(CH_NL);
    add_comments();
    add_value(1'b0);
    if ($urandom_range(4) == 0)
      file_bytes.push_back(CH_CR);
    file_bytes.push_back(CH_NL);
  endtask

  // Move the built file into the stream
  task automatic ship_file(input logic first, input logic mark_last);
    stim_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.data  = file_bytes[i];
      it.first = first && (i == 0);
      it.last  = mark_last && (i == file_bytes.size() - 1);
      it.pause = 1'b0;
      byte_stream_q.push_back(it);
    end
    stream_len += file_bytes.size();
    file_bytes.delete();
  endtask

  task automatic ship_pause();
    stim_item_t it;
    it = '0;
    it.pause = 1'b1;
    byte_stream_q.push_back(it);
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------- clock and reset

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Cycle count and one long receiver hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      tick      <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      tick <= tick + 1;
      if (!hold_done && results_seen >= 20) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    hdr_result_t r;
    stim_item_t  it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_tlast  <= 1'b0;
    end else begin
      // predict on each accepted transfer
      if (in_tvalid && in_tready) begin
        bytes_taken <= bytes_taken + 1;
        if (parse_byte(in_tdata, in_tuser, in_tlast, r))
          header_expect_q.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (byte_stream_q.size() != 0 && byte_stream_q[0].pause &&
            header_expect_q.size() == 0)
          void'(byte_stream_q.pop_front());
        if (byte_stream_q.size() != 0 && !byte_stream_q[0].pause &&
            (steady || $urandom_range(99) >= 29)) begin
          it = byte_stream_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= it.data;
          in_tuser  <= it.first;
          in_tlast  <= it.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    hdr_result_t got;
    hdr_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.width  = out_tdata[VAL_W-1:0];
        got.height = out_tdata[2*VAL_W-1:VAL_W];
        got.maxval = out_tdata[3*VAL_W-1:2*VAL_W];
        got.nbytes = out_tdata[4*VAL_W-1:3*VAL_W];
        got.status = status_t'(out_tuser);
        results_seen <= results_seen + 1;
        if (header_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result w=%0d h=%0d m=%0d n=%0d st=%0d",
                               got.width, got.height, got.maxval, got.nbytes, got.status));
        end else begin
          want = header_expect_q.pop_front();
          if (got.width !== want.width)
            flag_error($sformatf("width exp %0d got %0d", want.width, got.width));
          if (got.height !== want.height)
            flag_error($sformatf("height exp %0d got %0d", want.height, got.height));
          if (got.maxval !== want.maxval)
            flag_error($sformatf("maxval exp %0d got %0d", want.maxval, got.maxval));
          if (got.nbytes !== want.nbytes)
            flag_error($sformatf("header bytes exp %0d got %0d", want.nbytes, got.nbytes));
          if (got.status !== want.status)
            flag_error($sformatf("status exp %0d got %0d", want.status, got.status));
        end
      end
      out_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 29);
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    int unsigned rand_start;
    int unsigned kind;
    int unsigned cut;
    logic        paused_mid;

    clear_parse();
    paused_mid  = 1'b0;

    // plain header straight after reset, no first-byte flag
    add_text("P6\n640 480\n255\n");
    ship_file(1'b0, 1'b0);
    // comments before every line, maxval at the top of the range
    add_text("# top\nP3\n# mid\n12 34\n#\n65535\n");
    ship_file(1'b1, 1'b0);
    // values saturate; last flag on the closing newline is still a clean result
    add_text("P6\n99999 123456\n70000\n");
    ship_file(1'b1, 1'b1);
    // blanks skipped before digits
    add_text("P6\n");
    file_bytes.push_back(CH_TAB);
    file_bytes.push_back(CH_CR);
    add_text("7 ");
    file_bytes.push_back(CH_TAB);
    add_text("8\n ");
    file_bytes.push_back(CH_TAB);
    file_bytes.push_back(CH_VT);
    file_bytes.push_back(CH_FF);
    file_bytes.push_back(CH_CR);
    add_text("9\n");
    ship_file(1'b1, 1'b0);
    // size line without a space: height stays zero
    add_text("P5\n42\n1\n");
    ship_file(1'b1, 1'b0);
    // signs end the value at zero
    add_text("P6\n-5 +7\n-1\n");
    ship_file(1'b1, 1'b0);
    // trailing junk ends each value
    add_text("P6\n12a3 4x5\n2b55\n");
    ship_file(1'b1, 1'b0);
    // three empty lines
    add_text("\n\n\n");
    ship_file(1'b1, 1'b0);
    // hash away from line start is ordinary data
    add_text("P6 #x\n1#2 3\n4\n");
    ship_file(1'b1, 1'b0);
    // data ends mid-line, on an early newline, and on the first byte
    add_text("P6\n640 48");
    ship_file(1'b1, 1'b1);
    add_text("P6\n");
    ship_file(1'b1, 1'b1);
    add_text("P");
    ship_file(1'b1, 1'b1);
    // over-long comment on the final byte: length error wins over early end,
    // and the byte count shows the longest allowed length still went through
    add_text("P6\n1 2\n#");
    add_run(8'h78, LINE_LIMIT - 1);
    ship_file(1'b1, 1'b1);
    // bytes after a result are ignored until the next first byte
    add_text("1\n2 3\n4\n");
    ship_file(1'b1, 1'b0);
    add_text("junk\n5\n\n");
    ship_file(1'b0, 1'b1);
    // abandoned file restarted by a first byte
    add_text("P6\n10 ");
    ship_file(1'b1, 1'b0);
    add_text("P");
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    add_text("\n#");
    file_bytes.push_back(8'h80);
    file_bytes.push_back(8'h7F);
    add_text("\n0 0\n0\n");
    ship_file(1'b1, 1'b0);
    ship_pause();

    // random files, mostly well formed, up to the total byte budget
    rand_start = stream_len;
    while (stream_len < 1800) begin
      kind = $urandom_range(99);
      if (!paused_mid && stream_len > rand_start + (1800 - rand_start) / 2) begin
        ship_pause();
        paused_mid = 1'b1;
      end
      if (kind < 70) begin
        build_header();
        ship_file(1'b1, $urandom_range(3) == 0);
      end else if (kind < 80) begin
        // truncated with the last flag
        build_header();
        cut = $urandom_range(file_bytes.size(), 1);
        while (file_bytes.size() > cut)
          void'(file_bytes.pop_back());
        ship_file(1'b1, 1'b1);
      end else if (kind < 85) begin
        // result followed by stray bytes
        build_header();
        ship_file(1'b1, 1'b0);
        repeat ($urandom_range(8, 1)) file_bytes.push_back(8'($urandom_range(255)));
        ship_file(1'b0, $urandom_range(1));
      end else if (kind < 92) begin
        // abandoned part way, next file restarts
        build_header();
        cut = $urandom_range(file_bytes.size(), 1);
        while (file_bytes.size() > cut)
          void'(file_bytes.pop_back());
        ship_file(1'b1, 1'b0);
      end else begin
        // noise bytes with random flags
        repeat ($urandom_range(6, 1)) begin
          file_bytes.push_back(8'($urandom_range(255)));
          ship_file($urandom_range(1), $urandom_range(1));
        end
      end
    end

    wait (rst_n === 1'b1);
    while (bytes_taken != stream_len)
      @(posedge clk);
    while (header_expect_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && header_expect_q.size() == 0)
      $display("ppm_header_parser_tb: done, clean");
    else
      $display("ppm_header_parser_tb: done, errors");
    $finish;
  end

  initial begin
    #(6_000_000);
    $display("ppm_header_parser_tb: done, errors");
    $finish;
  end

endmodule
